### rtl/glrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glrs_pkg
// Shared constants, codes and control/status types of the glyph span renderer.
// ----------------------------------------------------------------------------
package glrs_pkg;

    // Glyph geometry of the loaded font
    localparam int GLYPH_WIDTH  = 8;
    localparam int GLYPH_HEIGHT = 16;
    localparam int GLYPH_COUNT  = 128;
    localparam int ROW_BYTES    = 1;

    // Font store
    localparam int STORE_WIDTH = 8;
    localparam int STORE_DEPTH = 2048;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    // Most spans per draw beat
    localparam int MAX_SPANS = 8;

    // Derived widths
    localparam int ROWB_W  = ROW_BYTES * 8;
    localparam int COL_W   = $clog2(GLYPH_WIDTH + 1);
    localparam int COL_N   = 1 << COL_W;
    localparam int SC_W    = COL_W + 4;
    localparam int RCNT_W  = $clog2(ROW_BYTES + 1);
    localparam int NCNT_W  = $clog2(MAX_SPANS + 1);
    localparam int FA_W    = 16;
    localparam int Y_W     = 18;
    localparam int CX_W    = 18;

    // Stream payload widths
    localparam int S_TDATA_W = 80;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 104;
    localparam int M_TUSER_W = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_WIDTH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_HEIGHT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_STRIDE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FB_PRESENT  = 3'd6;

    // Configuration reset values
    localparam logic [3:0]  RST_SCALE       = 4'd1;
    localparam logic [12:0] RST_FB_WIDTH    = 13'd640;
    localparam logic [12:0] RST_FB_HEIGHT   = 13'd480;
    localparam logic [13:0] RST_LINE_STRIDE = 14'd640;
    localparam logic [31:0] RST_FG_COLOR    = 32'hFFFF_FFFF;
    localparam logic [31:0] RST_BG_COLOR    = 32'h0000_0000;
    localparam logic        RST_FB_PRESENT  = 1'b1;

    // Input kinds
    localparam logic KIND_DRAW = 1'b0;
    localparam logic KIND_LOAD = 1'b1;

    // Output register source select
    localparam logic [1:0] SEL_SPAN   = 2'd0;
    localparam logic [1:0] SEL_EMPTY  = 2'd1;
    localparam logic [1:0] SEL_REJECT = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic       accept;
        logic       start;
        logic       fetch;
        logic       scan;
        logic       clip;
        logic       take;
        logic       push;
        logic       push_last;
        logic [1:0] push_sel;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic reject;
        logic fetch_done;
        logic line_ok;
        logic run_end;
        logic col_done;
        logic keep;
        logic room;
        logic pend_valid;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

### rtl/glrs_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glrs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module glrs_ram #(
    parameter  int WIDTH = glrs_pkg::STORE_WIDTH,
    parameter  int DEPTH = glrs_pkg::STORE_DEPTH,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, read one entry into the output register
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

### rtl/glrs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glrs_ctrl
// Sequencer for one draw beat: fetch glyph row, scan runs, clip, emit spans.
// ----------------------------------------------------------------------------
module glrs_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    input  wire logic              kind,
    output logic                   s_tready,
    input  wire glrs_pkg::status_t sts,
    output glrs_pkg::cmd_t         cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_REJ   = 3'd1;
    localparam logic [2:0] ST_ADDR  = 3'd2;
    localparam logic [2:0] ST_FETCH = 3'd3;
    localparam logic [2:0] ST_SCAN  = 3'd4;
    localparam logic [2:0] ST_CLIP  = 3'd5;
    localparam logic [2:0] ST_TRIM  = 3'd6;
    localparam logic [2:0] ST_FINAL = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Decode commands and next state
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.push_sel = glrs_pkg::SEL_SPAN;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid && (kind == glrs_pkg::KIND_DRAW))
                begin
                    state_next = sts.reject ? ST_REJ : ST_ADDR;
                end
            end
            ST_REJ:
            begin
                if (sts.out_free)
                begin
                    cmd.push      = 1'b1;
                    cmd.push_last = 1'b1;
                    cmd.push_sel  = glrs_pkg::SEL_REJECT;
                    state_next    = ST_IDLE;
                end
            end
            ST_ADDR:
            begin
                cmd.start  = 1'b1;
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                cmd.fetch = 1'b1;
                if (sts.fetch_done)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!sts.line_ok)
                begin
                    state_next = ST_FINAL;
                end
                else
                begin
                    cmd.scan = 1'b1;
                    if (sts.run_end)
                    begin
                        state_next = ST_CLIP;
                    end
                end
            end
            ST_CLIP:
            begin
                cmd.clip   = 1'b1;
                state_next = ST_TRIM;
            end
            ST_TRIM:
            begin
                // Hold while the previous span cannot move to the output
                if (sts.keep && sts.room && sts.pend_valid && !sts.out_free)
                begin
                    state_next = ST_TRIM;
                end
                else
                begin
                    if (sts.keep && sts.room)
                    begin
                        cmd.take     = 1'b1;
                        cmd.push     = sts.pend_valid;
                        cmd.push_sel = glrs_pkg::SEL_SPAN;
                    end
                    state_next = sts.col_done ? ST_FINAL : ST_SCAN;
                end
            end
            ST_FINAL:
            begin
                if (sts.out_free)
                begin
                    cmd.push      = 1'b1;
                    cmd.push_last = 1'b1;
                    cmd.push_sel  = sts.pend_valid ? glrs_pkg::SEL_SPAN
                                                   : glrs_pkg::SEL_EMPTY;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

### rtl/glrs_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glrs_dp
// Datapath: configuration, font store, run scan, scaling, clipping, output.
// ----------------------------------------------------------------------------
module glrs_dp (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire glrs_pkg::cmd_t                       cmd,
    output glrs_pkg::status_t                         sts,
    input  wire logic [glrs_pkg::S_TDATA_W-1:0]       s_tdata,
    input  wire logic [glrs_pkg::S_TUSER_W-1:0]       s_tuser,
    input  wire logic                                 cfg_valid,
    input  wire logic [glrs_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [glrs_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic      [glrs_pkg::M_TDATA_W-1:0]       m_tdata,
    output logic      [glrs_pkg::M_TUSER_W-1:0]       m_tuser,
    output logic                                      m_tlast
);

    localparam int ROWB_W = glrs_pkg::ROWB_W;
    localparam int COL_W  = glrs_pkg::COL_W;
    localparam int COL_N  = glrs_pkg::COL_N;
    localparam int SC_W   = glrs_pkg::SC_W;
    localparam int RCNT_W = glrs_pkg::RCNT_W;
    localparam int NCNT_W = glrs_pkg::NCNT_W;
    localparam int FA_W   = glrs_pkg::FA_W;
    localparam int Y_W    = glrs_pkg::Y_W;
    localparam int CX_W   = glrs_pkg::CX_W;
    localparam int AW     = glrs_pkg::STORE_AW;

    // Configuration registers
    logic [3:0]  scale_reg;
    logic [12:0] fb_width_reg;
    logic [12:0] fb_height_reg;
    logic [13:0] line_stride_reg;
    logic [31:0] fg_reg;
    logic [31:0] bg_reg;
    logic        fb_present_reg;

    // Input beat fields
    logic [7:0]         in_char;
    logic [7:0]         in_pos;
    logic signed [15:0] in_ox;
    logic signed [15:0] in_oy;
    logic [4:0]         in_row;
    logic [3:0]         in_sub;
    logic [11:0]        in_addr;
    logic [7:0]         in_byte;

    // Item registers
    logic [7:0]         glyph_reg;
    logic [7:0]         pos_reg;
    logic signed [15:0] ox_reg;
    logic signed [15:0] oy_reg;
    logic [4:0]         row_reg;
    logic [3:0]         sub_reg;

    logic signed [Y_W-1:0]  y_reg;
    logic signed [CX_W-1:0] cx_reg;
    logic [26:0]            ybase_reg;
    logic                   line_ok_reg;

    // Font fetch
    logic [RCNT_W-1:0] rd_cnt_reg;
    logic [RCNT_W-1:0] rd_idx;
    logic [FA_W-1:0]   row_base;
    logic [FA_W-1:0]   faddr;
    logic              ram_re;
    logic              ram_we;
    logic [7:0]        ram_rdata;
    logic              oob_reg;
    logic [7:0]        byte_in;
    logic [ROWB_W-1:0] row_bits_reg;

    // Run scan
    logic [COL_N-1:0] gbits;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_p1;
    logic [COL_W-1:0] rs_reg;
    logic [COL_W-1:0] run_start_reg;
    logic [COL_W-1:0] run_len_reg;
    logic             run_bit_reg;
    logic             cur_bit;
    logic             nxt_bit;

    // Scale and clip
    logic [8:0]             row_scaled;
    logic [11:0]            pos_gw;
    logic [15:0]            cx_adv;
    logic signed [Y_W-1:0]  y_calc;
    logic signed [CX_W-1:0] cx_calc;
    logic [SC_W-1:0]        st_scaled;
    logic [SC_W-1:0]        cnt_reg;
    logic signed [CX_W-1:0] sx_reg;
    logic                   sx_neg;
    logic signed [CX_W-1:0] sum_l;
    logic signed [CX_W-1:0] avail_pos;
    logic signed [CX_W-1:0] fbw_s;
    logic signed [CX_W-1:0] cnt1;
    logic signed [CX_W-1:0] avail;
    logic signed [CX_W-1:0] cnt_f;
    logic [12:0]            span_x;
    logic [27:0]            span_off;
    logic                   keep;

    // Pending span and output register
    logic [NCNT_W-1:0] n_reg;
    logic              pend_valid_reg;
    logic [12:0]       pend_x_reg;
    logic [12:0]       pend_y_reg;
    logic [12:0]       pend_cnt_reg;
    logic [31:0]       pend_color_reg;
    logic [27:0]       pend_off_reg;

    logic                          out_valid_reg;
    logic [glrs_pkg::M_TDATA_W-1:0] out_data_reg;
    logic [glrs_pkg::M_TUSER_W-1:0] out_user_reg;
    logic                          out_last_reg;
    logic                          out_free;

    // Unpack the input beat
    assign in_char = s_tdata[7:0];
    assign in_pos  = s_tdata[15:8];
    assign in_ox   = $signed(s_tdata[31:16]);
    assign in_oy   = $signed(s_tdata[47:32]);
    assign in_row  = s_tdata[52:48];
    assign in_sub  = s_tdata[56:53];
    assign in_addr = s_tdata[68:57];
    assign in_byte = s_tdata[76:69];

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg       <= glrs_pkg::RST_SCALE;
            fb_width_reg    <= glrs_pkg::RST_FB_WIDTH;
            fb_height_reg   <= glrs_pkg::RST_FB_HEIGHT;
            line_stride_reg <= glrs_pkg::RST_LINE_STRIDE;
            fg_reg          <= glrs_pkg::RST_FG_COLOR;
            bg_reg          <= glrs_pkg::RST_BG_COLOR;
            fb_present_reg  <= glrs_pkg::RST_FB_PRESENT;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                glrs_pkg::CFG_SCALE:       scale_reg       <= cfg_data[3:0];
                glrs_pkg::CFG_FB_WIDTH:    fb_width_reg    <= cfg_data[12:0];
                glrs_pkg::CFG_FB_HEIGHT:   fb_height_reg   <= cfg_data[12:0];
                glrs_pkg::CFG_LINE_STRIDE: line_stride_reg <= cfg_data[13:0];
                glrs_pkg::CFG_FG_COLOR:    fg_reg          <= cfg_data[31:0];
                glrs_pkg::CFG_BG_COLOR:    bg_reg          <= cfg_data[31:0];
                glrs_pkg::CFG_FB_PRESENT:  fb_present_reg  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    // Font store: load beats write, draw beats read row bytes
    assign ram_we = cmd.accept && (s_tuser[0] == glrs_pkg::KIND_LOAD)
                    && (in_addr < 12'(glrs_pkg::STORE_DEPTH));
    assign rd_idx   = cmd.start ? '0 : rd_cnt_reg;
    assign row_base = (FA_W'(glyph_reg) * FA_W'(glrs_pkg::GLYPH_HEIGHT) + FA_W'(row_reg))
                      * FA_W'(glrs_pkg::ROW_BYTES);
    assign faddr    = row_base + FA_W'(rd_idx);
    assign ram_re   = cmd.start
                      || (cmd.fetch && (rd_cnt_reg < RCNT_W'(glrs_pkg::ROW_BYTES)));
    assign byte_in  = oob_reg ? 8'h00 : ram_rdata;

    glrs_ram #(
        .WIDTH (glrs_pkg::STORE_WIDTH),
        .DEPTH (glrs_pkg::STORE_DEPTH)
    ) u_font (
        .clk   (clk),
        .we    (ram_we),
        .waddr (in_addr[AW-1:0]),
        .wdata (in_byte),
        .re    (ram_re),
        .raddr (faddr[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Line and cell origin
    assign row_scaled = 9'(row_reg) * 9'(scale_reg);
    assign y_calc     = Y_W'(oy_reg) + $signed(Y_W'(row_scaled)) + $signed(Y_W'(sub_reg));
    assign pos_gw     = 12'(pos_reg) * 12'(glrs_pkg::GLYPH_WIDTH);
    assign cx_adv     = 16'(pos_gw) * 16'(scale_reg);
    assign cx_calc    = CX_W'(ox_reg) + $signed(CX_W'(cx_adv));

    // Glyph bits, leftmost pixel at index zero
    always_comb
    begin
        gbits = '0;
        for (int c = 0; c < COL_N; c++)
        begin
            if (c < glrs_pkg::GLYPH_WIDTH)
            begin
                gbits[c] = row_bits_reg[ROWB_W-1-c];
            end
        end
    end

    assign col_p1  = col_reg + 1'b1;
    assign cur_bit = gbits[col_reg];
    assign nxt_bit = gbits[col_p1];

    // Run ends at the last column or where the colour changes
    assign sts.run_end  = (col_reg == COL_W'(glrs_pkg::GLYPH_WIDTH - 1))
                          || ((cur_bit != nxt_bit) && (fg_reg != bg_reg));
    assign sts.col_done = (col_reg == COL_W'(glrs_pkg::GLYPH_WIDTH));

    assign st_scaled = SC_W'(run_start_reg) * SC_W'(scale_reg);

    // Clip the scaled run against left and right edges
    assign sx_neg    = sx_reg[CX_W-1];
    assign sum_l     = sx_reg + $signed(CX_W'(cnt_reg));
    assign fbw_s     = $signed(CX_W'(fb_width_reg));
    assign avail_pos = fbw_s - sx_reg;

    always_comb
    begin
        if (sx_neg)
        begin
            keep  = (sum_l > 0) && (fb_width_reg != 13'd0);
            cnt1  = sum_l;
            avail = fbw_s;
        end
        else
        begin
            keep  = sx_reg < fbw_s;
            cnt1  = $signed(CX_W'(cnt_reg));
            avail = avail_pos;
        end
        cnt_f    = (cnt1 > avail) ? avail : cnt1;
        span_x   = sx_neg ? 13'd0 : sx_reg[12:0];
        span_off = sx_neg ? 28'(ybase_reg) : 28'(ybase_reg) + 28'(sx_reg[12:0]);
    end

    assign out_free = !out_valid_reg || m_tready;

    assign sts.reject     = (scale_reg == 4'd0) || !fb_present_reg;
    assign sts.fetch_done = (rd_cnt_reg == RCNT_W'(glrs_pkg::ROW_BYTES));
    assign sts.line_ok    = line_ok_reg;
    assign sts.keep       = keep;
    assign sts.room       = n_reg < NCNT_W'(glrs_pkg::MAX_SPANS);
    assign sts.pend_valid = pend_valid_reg;
    assign sts.out_free   = out_free;

    // Item payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            glyph_reg <= ({1'b0, in_char} < 9'(glrs_pkg::GLYPH_COUNT)) ? in_char : 8'd0;
            pos_reg   <= in_pos;
            ox_reg    <= in_ox;
            oy_reg    <= in_oy;
            row_reg   <= in_row;
            sub_reg   <= in_sub;
        end
        if (cmd.start)
        begin
            y_reg  <= y_calc;
            cx_reg <= cx_calc;
        end
        if (ram_re)
        begin
            oob_reg <= faddr >= FA_W'(glrs_pkg::STORE_DEPTH);
        end
        if (cmd.fetch)
        begin
            row_bits_reg <= (row_bits_reg << 8) | ROWB_W'(byte_in);
            ybase_reg    <= 27'(y_reg[12:0]) * 27'(line_stride_reg);
            line_ok_reg  <= (6'(row_reg) < 6'(glrs_pkg::GLYPH_HEIGHT))
                            && (sub_reg < scale_reg)
                            && !y_reg[Y_W-1]
                            && ($unsigned(y_reg) < Y_W'(fb_height_reg));
        end
        if (cmd.scan && sts.run_end)
        begin
            run_start_reg <= rs_reg;
            run_len_reg   <= col_p1 - rs_reg;
            run_bit_reg   <= cur_bit;
        end
        if (cmd.clip)
        begin
            sx_reg  <= cx_reg + $signed(CX_W'(st_scaled));
            cnt_reg <= SC_W'(run_len_reg) * SC_W'(scale_reg);
        end
        if (cmd.take)
        begin
            pend_x_reg     <= span_x;
            pend_y_reg     <= y_reg[12:0];
            pend_cnt_reg   <= cnt_f[12:0];
            pend_color_reg <= run_bit_reg ? fg_reg : bg_reg;
            pend_off_reg   <= span_off;
        end
    end

    // Counters and pending span flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_cnt_reg     <= '0;
            col_reg        <= '0;
            rs_reg         <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                rd_cnt_reg     <= RCNT_W'(1);
                col_reg        <= '0;
                rs_reg         <= '0;
                n_reg          <= '0;
                pend_valid_reg <= 1'b0;
            end
            else
            begin
                if (cmd.fetch && (rd_cnt_reg < RCNT_W'(glrs_pkg::ROW_BYTES)))
                begin
                    rd_cnt_reg <= rd_cnt_reg + 1'b1;
                end
                if (cmd.scan)
                begin
                    col_reg <= col_p1;
                    if (sts.run_end)
                    begin
                        rs_reg <= col_p1;
                    end
                end
                if (cmd.take)
                begin
                    n_reg          <= n_reg + 1'b1;
                    pend_valid_reg <= 1'b1;
                end
                else if (cmd.push && cmd.push_last)
                begin
                    pend_valid_reg <= 1'b0;
                end
            end
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            out_last_reg <= cmd.push_last;
            unique case (cmd.push_sel)
                glrs_pkg::SEL_SPAN:
                begin
                    out_data_reg <= {5'd0, pend_off_reg, pend_color_reg,
                                     pend_cnt_reg, pend_y_reg, pend_x_reg};
                    out_user_reg <= 2'b01;
                end
                glrs_pkg::SEL_REJECT:
                begin
                    out_data_reg <= '0;
                    out_user_reg <= 2'b10;
                end
                default:
                begin
                    out_data_reg <= '0;
                    out_user_reg <= 2'b00;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

### rtl/glyph_line_span_renderer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// A load beat is written into the font store; a rejected draw yields a lone final beat.
// A draw fetches the glyph row, scans it one column per cycle up to each run end,
// then clips each run; the clip step may hold while the output register is full.
// A span is shown once the next one is known, so the final span carries tlast.
// Reset restores configuration defaults and clears control; the font store
// holds no defined contents until loaded and has no clearing pass.
// ----------------------------------------------------------------------------
// glyph_line_span_renderer_core
// Bitmap font glyph line renderer producing clipped spans of equal color.
// ----------------------------------------------------------------------------
module glyph_line_span_renderer_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // character, char_position, origin_x, origin_y, glyph_row, sub_row,
    // rom_address, rom_byte (from bit 0 up), zero filled
    input  wire logic [glrs_pkg::S_TDATA_W-1:0]      s_tdata,
    // kind
    input  wire logic [glrs_pkg::S_TUSER_W-1:0]      s_tuser,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // span_x, span_y, span_count, span_color, pixel_offset (from bit 0 up)
    output logic      [glrs_pkg::M_TDATA_W-1:0]      m_tdata,
    // span_valid, rejected (from bit 0 up)
    output logic      [glrs_pkg::M_TUSER_W-1:0]      m_tuser,
    output logic                                     m_tlast,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [glrs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [glrs_pkg::CFG_DATA_W-1:0]     cfg_data
);

    glrs_pkg::cmd_t    cmd;
    glrs_pkg::status_t sts;

    // Registers take a write in any cycle
    assign cfg_ready = 1'b1;

    glrs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .kind     (s_tuser[0]),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    glrs_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire

### rtl/glrs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glrs_checker
// Port-level checks on the span output stream of the renderer.
// ----------------------------------------------------------------------------
module glrs_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [glrs_pkg::M_TDATA_W-1:0]    m_tdata,
    input wire logic [glrs_pkg::M_TUSER_W-1:0]    m_tuser,
    input wire logic                              m_tlast
);

    // A rejected beat is the only result of its draw and carries no span
    a_reject_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (m_tlast && !m_tuser[0] && (m_tdata == '0)))
        else $error("rejected beat is not a lone empty final beat");

    // A beat without a span is final and all zero
    a_empty_final: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tlast && (m_tdata == '0)))
        else $error("beat without span is not a zero final beat");

    // A span beat never has a zero pixel count
    a_span_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[38:26] != 13'd0))
        else $error("span beat with zero count");

    // A stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)
                                     && $stable(m_tuser) && $stable(m_tlast)))
        else $error("output beat changed while stalled");

endmodule

bind glyph_line_span_renderer_core glrs_checker u_glrs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the glyph line span renderer core. Font bytes and
// draw beats go in on the slave stream, register writes on the config
// channel. A behavioral line renderer predicts every span beat, and a monitor
// on the master stream compares each beat with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import glrs_pkg::*;

    localparam int RUN_LIMIT    = 1_000_000;
    localparam int DRAIN_CYCLES = 40;
    localparam int ERR_SHOWN    = 10;

    // One input beat, either a font byte load or a draw of one output line
    typedef struct packed {
        logic        kind;
        logic [7:0]  ch;
        logic [7:0]  pos;
        logic [15:0] ox;
        logic [15:0] oy;
        logic [4:0]  row;
        logic [3:0]  sub;
        logic [11:0] addr;
        logic [7:0]  data;
    } item_t;

    // One span beat as seen on the master stream
    typedef struct packed {
        logic        valid;
        logic [12:0] x;
        logic [12:0] y;
        logic [12:0] count;
        logic [31:0] color;
        logic [27:0] offset;
        logic        rejected;
        logic        last;
    } span_t;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [S_TUSER_W-1:0]   s_tuser   = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   m_tlast;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Shadow of the register file and the font store
    int          scl    = int'(RST_SCALE);
    int          fbw    = int'(RST_FB_WIDTH);
    int          fbh    = int'(RST_FB_HEIGHT);
    int          stride = int'(RST_LINE_STRIDE);
    logic [31:0] fg_col = RST_FG_COLOR;
    logic [31:0] bg_col = RST_BG_COLOR;
    logic        fb_on  = RST_FB_PRESENT;
    logic [7:0]  font_img [0:STORE_DEPTH-1];
    bit          font_set [0:STORE_DEPTH-1];

    span_t span_q[$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int n_draws     = 0;
    int n_loads     = 0;
    int n_spans     = 0;
    int n_errs      = 0;
    int n_settings  = 0;
    int cycles      = 0;

    glyph_line_span_renderer_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 100 MHz clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Stall the master side at random
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > RUN_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d spans outstanding", cycles, span_q.size());
            $display("FAIL");
            $finish;
        end
    end

    // Compare every span beat with the oldest prediction
    always @(posedge clk)
    begin : span_mon
        span_t got;
        span_t want;
        if (m_tvalid && m_tready)
        begin
            got.valid    = m_tuser[0];
            got.rejected = m_tuser[1];
            got.x        = m_tdata[12:0];
            got.y        = m_tdata[25:13];
            got.count    = m_tdata[38:26];
            got.color    = m_tdata[70:39];
            got.offset   = m_tdata[98:71];
            got.last     = m_tlast;
            n_spans++;
            if (span_q.size() == 0)
            begin
                n_errs++;
                if (n_errs <= ERR_SHOWN)
                    $display("unexpected span beat %0d: x %0d y %0d n %0d last %0b",
                             n_spans, got.x, got.y, got.count, got.last);
            end
            else
            begin
                want = span_q.pop_front();
                if (got !== want)
                begin
                    n_errs++;
                    if (n_errs <= ERR_SHOWN)
                    begin
                        $display("span beat %0d mismatch", n_spans);
                        $display("  exp v%0b x %0d y %0d n %0d c %08h off %0d rej %0b last %0b",
                                 want.valid, want.x, want.y, want.count, want.color,
                                 want.offset, want.rejected, want.last);
                        $display("  got v%0b x %0d y %0d n %0d c %08h off %0d rej %0b last %0b",
                                 got.valid, got.x, got.y, got.count, got.color,
                                 got.offset, got.rejected, got.last);
                    end
                end
            end
        end
    end

    // Color of one glyph pixel from the shadow font
    function automatic logic [31:0] pix_color(input int glyph, input int row, input int col);
        int a;
        a = (glyph * GLYPH_HEIGHT + row) * ROW_BYTES + col / 8;
        return font_img[a][7 - col % 8] ? fg_col : bg_col;
    endfunction

    // Render one glyph line into the queue of expected span beats
    function automatic void predict_spans(input item_t it);
        span_t  pend;
        bit     have;
        longint y;
        longint cx;
        longint sx;
        longint cnt;
        longint off;
        int     glyph;
        int     col;
        int     run;
        int     n;
        logic [31:0] colr;
        pend = '0;
        have = 1'b0;
        n    = 0;
        if (scl == 0 || !fb_on)
        begin
            pend.rejected = 1'b1;
            pend.last     = 1'b1;
            span_q.push_back(pend);
            return;
        end
        glyph = (it.ch < GLYPH_COUNT) ? int'(it.ch) : 0;
        y  = longint'($signed(it.oy)) + longint'(it.row) * scl + longint'(it.sub);
        cx = longint'($signed(it.ox)) + longint'(it.pos) * GLYPH_WIDTH * scl;
        if (int'(it.row) < GLYPH_HEIGHT && int'(it.sub) < scl && y >= 0 && y < fbh)
        begin
            col = 0;
            while (col < GLYPH_WIDTH)
            begin
                // merge equal colors into one run
                colr = pix_color(glyph, int'(it.row), col);
                run  = 1;
                while (col + run < GLYPH_WIDTH && pix_color(glyph, int'(it.row), col + run) == colr)
                    run++;
                sx  = cx + longint'(col) * scl;
                cnt = longint'(run) * scl;
                col += run;
                // clip left, then right
                if (sx < 0)
                begin
                    if (-sx >= cnt)
                        continue;
                    cnt += sx;
                    sx = 0;
                end
                if (sx < fbw)
                begin
                    if (cnt > fbw - sx)
                        cnt = fbw - sx;
                    if (n < MAX_SPANS)
                    begin
                        if (have)
                            span_q.push_back(pend);
                        off          = y * stride + sx;
                        pend         = '0;
                        pend.valid   = 1'b1;
                        pend.x       = sx[12:0];
                        pend.y       = y[12:0];
                        pend.count   = cnt[12:0];
                        pend.color   = colr;
                        pend.offset  = off[27:0];
                        have         = 1'b1;
                        n++;
                    end
                end
            end
        end
        // hold the last span back so it carries the end mark
        pend.last = 1'b1;
        span_q.push_back(pend);
    endfunction

    // Drive one beat on the slave stream and wait for its handshake
    task automatic push_beat(input item_t it);
        @(negedge clk);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_tdata  <= {3'b000, it.data, it.addr, it.sub, it.row, it.oy, it.ox, it.pos, it.ch};
        s_tuser  <= it.kind;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic load_byte(input int addr, input int val);
        item_t it;
        it      = '0;
        it.kind = KIND_LOAD;
        it.addr = addr[11:0];
        it.data = val[7:0];
        push_beat(it);
        if (addr < STORE_DEPTH)
        begin
            font_img[addr] = val[7:0];
            font_set[addr] = 1'b1;
        end
        n_loads++;
    endtask

    task automatic draw_line(input int ch, input int pos, input int ox, input int oy,
                             input int row, input int sub);
        item_t it;
        int    faddr;
        it      = '0;
        it.kind = KIND_DRAW;
        it.ch   = ch[7:0];
        it.pos  = pos[7:0];
        it.ox   = ox[15:0];
        it.oy   = oy[15:0];
        it.row  = row[4:0];
        it.sub  = sub[3:0];
        // never let the block use a font byte that was not loaded
        if (int'(it.row) < GLYPH_HEIGHT)
        begin
            faddr = ((it.ch < GLYPH_COUNT) ? int'(it.ch) : 0) * GLYPH_HEIGHT * ROW_BYTES
                    + int'(it.row) * ROW_BYTES;
            if (!font_set[faddr])
                load_byte(faddr, $urandom_range(255));
        end
        predict_spans(it);
        push_beat(it);
        n_draws++;
    endtask

    // Release the slave stream and wait until every expected span has come
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (span_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_SCALE:       scl    = int'(val[3:0]);
            CFG_FB_WIDTH:    fbw    = int'(val[12:0]);
            CFG_FB_HEIGHT:   fbh    = int'(val[12:0]);
            CFG_LINE_STRIDE: stride = int'(val[13:0]);
            CFG_FG_COLOR:    fg_col = val;
            CFG_BG_COLOR:    bg_col = val;
            CFG_FB_PRESENT:  fb_on  = val[0];
            default: ;
        endcase
    endtask

    // Write the whole register file once the block has gone idle
    task automatic apply_settings(input int sc, input int w, input int h, input int st,
                                  input logic [31:0] fg, input logic [31:0] bg,
                                  input logic present);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_reg(CFG_SCALE,       32'(sc));
        write_reg(CFG_FB_WIDTH,    32'(w));
        write_reg(CFG_FB_HEIGHT,   32'(h));
        write_reg(CFG_LINE_STRIDE, 32'(st));
        write_reg(CFG_FG_COLOR,    fg);
        write_reg(CFG_BG_COLOR,    bg);
        write_reg(CFG_FB_PRESENT,  {31'd0, present});
        @(negedge clk);
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    // Glyph handling at reset settings: runs, fallback glyph, clipping
    task automatic test_directed_glyphs();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        load_byte(65 * GLYPH_HEIGHT, 8'hAA);
        load_byte(0, 8'h3C);
        load_byte(GLYPH_HEIGHT - 1, 8'hFF);
        load_byte(12'hFFF, 8'hFF);
        load_byte(STORE_DEPTH + 5, 8'h5A);
        // eight alternating runs give the full span count
        draw_line(65, 0, 0, 0, 0, 0);
        draw_line(200, 0, 10, 20, 0, 0);
        // left clip through a far character position
        draw_line(255, 255, -2043, 5, 15, 0);
        // right clip against the frame edge
        draw_line(65, 0, 636, 7, 0, 0);
        draw_line(65, 0, 0, 0, 16, 0);
        draw_line(65, 0, 0, 0, 31, 0);
        draw_line(65, 0, 0, 0, 0, 1);
        draw_line(65, 0, 0, -1, 0, 0);
        draw_line(65, 0, 0, 479, 0, 0);
        draw_line(65, 0, 0, 480, 0, 0);
        draw_line(65, 0, -32768, 0, 0, 0);
        draw_line(65, 0, 32767, 0, 0, 0);
        draw_line(65, 0, 0, -32768, 0, 0);
        draw_line(65, 0, 0, 32767, 0, 0);
        draw_line(127, 1, 100, 100, 7, 0);
    endtask

    // Register extremes: rejection, equal colors, empty frame, zero stride
    task automatic test_directed_config();
        apply_settings(0, 640, 480, 640, 32'hFFFF_FFFF, 32'h0, 1'b1);
        draw_line(65, 0, 0, 0, 0, 0);
        apply_settings(2, 640, 480, 640, 32'hFFFF_FFFF, 32'h0, 1'b0);
        draw_line(65, 0, 0, 0, 0, 0);
        apply_settings(15, 8191, 8191, 16383, 32'h1234_5678, 32'h1234_5678, 1'b1);
        draw_line(65, 0, 8091, 7951, 15, 14);
        draw_line(200, 3, -300, 0, 0, 0);
        apply_settings(1, 0, 480, 640, 32'hFFFF_FFFF, 32'h0, 1'b1);
        draw_line(65, 0, 0, 0, 0, 0);
        apply_settings(2, 640, 0, 0, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b1);
        draw_line(65, 0, 0, 0, 0, 0);
        apply_settings(2, 640, 1, 0, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b1);
        draw_line(65, 0, 3, 0, 0, 0);
        draw_line(65, 0, 3, 0, 0, 1);
    endtask

    // Random loads and draws over six register settings and three idle mixes
    task automatic test_random();
        int          blk;
        int          k;
        int          t;
        int          ch;
        int          pos;
        int          row;
        int          sub;
        int          ox;
        int          oy;
        int          dat;
        logic [31:0] c;
        for (blk = 0; blk < 6; blk++)
        begin
            c = $urandom;
            case (blk)
                0: apply_settings(1, 640, 480, 640, $urandom, $urandom, 1'b1);
                1: apply_settings(2, 200, 120, 256, $urandom, $urandom, 1'b1);
                2: apply_settings(3, 100, 60, 128, $urandom, $urandom, 1'b1);
                3: apply_settings($urandom_range(15), $urandom_range(8191), $urandom_range(8191),
                                  $urandom_range(16383), $urandom, $urandom,
                                  $urandom_range(9) != 0);
                4: apply_settings($urandom_range(1, 15), $urandom_range(1, 64),
                                  $urandom_range(1, 64), $urandom_range(64),
                                  $urandom, $urandom, 1'b1);
                default: apply_settings(15, 8191, 8191, 16383, c, c, 1'b1);
            endcase
            tx_idle_pct = (blk < 2) ? 18 : (blk < 4) ? 87 : 0;
            rx_idle_pct = (blk < 2) ? 87 : (blk < 4) ? 18 : 0;
            for (k = 0; k < 68; k++)
            begin
                if ($urandom_range(99) < 20)
                begin
                    // rewrite glyph rows that draws use, now and then beyond the store
                    t = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(255);
                    case ($urandom_range(3))
                        0: dat = 8'h00;
                        1: dat = 8'hFF;
                        default: dat = $urandom_range(255);
                    endcase
                    load_byte(t, dat);
                end
                else
                begin
                    ch  = ($urandom_range(1) == 0) ? $urandom_range(15) : $urandom_range(255);
                    row = ($urandom_range(9) == 0) ? $urandom_range(16, 31) : $urandom_range(15);
                    if (scl > 0 && $urandom_range(9) != 0)
                        sub = $urandom_range(scl - 1);
                    else
                        sub = $urandom_range(14);
                    t = $urandom_range(9);
                    if (t < 7)
                        pos = $urandom_range(4);
                    else if (t < 9)
                        pos = $urandom_range(40);
                    else
                        pos = $urandom_range(255);
                    // aim most cells at the frame and its edges
                    if ($urandom_range(3) == 0)
                        ox = $urandom_range(65535);
                    else
                    begin
                        t  = $urandom_range(fbw + 8 * scl + 8);
                        ox = t - 8 * scl - 4 - pos * GLYPH_WIDTH * scl;
                    end
                    if ($urandom_range(3) == 0)
                        oy = $urandom_range(65535);
                    else
                    begin
                        t  = $urandom_range(fbh + 3);
                        oy = t - 2 - row * scl - sub;
                    end
                    draw_line(ch, pos, ox, oy, row, sub);
                end
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed_glyphs();
        test_directed_config();
        test_random();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (span_q.size() != 0)
        begin
            n_errs += span_q.size();
            $display("%0d expected spans never arrived", span_q.size());
        end
        $display("Covered %0d line draws and %0d font writes over %0d register settings,",
                 n_draws, n_loads, n_settings);
        $display("with %0d span beats checked and %0d mismatches.", n_spans, n_errs);
        if (n_errs == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
